[src/assert_macros.svh]
// Assertion macros used by the port checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define ASSERT_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent assertion that also holds across reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[src/pedd_pkg.sv]
// Package with shared constants, register codes and a saturation helper for the palette ditherer.
`timescale 1ns / 1ps
package pedd_pkg;

  localparam int MAX_WIDTH_DEF     = 1024;
  localparam int PALETTE_DEPTH_DEF = 256;

  localparam int CFG_AW     = 4;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 8;

  typedef enum logic [1:0] {
    REG_PALETTE_SIZE  = 2'd0,
    REG_DITHER_ENABLE = 2'd1,
    REG_IMAGE_WIDTH   = 2'd2,
    REG_IMAGE_HEIGHT  = 2'd3
  } reg_index_t;

  // Operation codes carried in s_tuser.
  localparam logic [0:0] OP_PALETTE_WRITE = 1'b0;
  localparam logic [0:0] OP_PIXEL         = 1'b1;

  localparam logic [8:0]  PALETTE_SIZE_RST  = 9'd256;
  localparam logic        DITHER_ENABLE_RST = 1'b1;
  localparam logic [10:0] IMAGE_WIDTH_RST   = 11'd640;
  localparam logic [15:0] IMAGE_HEIGHT_RST  = 16'd480;

  localparam logic [7:0] TRANSPARENT_INDEX = 8'hFF;

  // Clamp an 18-bit signed sum into a signed 12.4 accumulator.
  function automatic logic signed [15:0] sat16(input logic signed [17:0] x);
    logic signed [15:0] r;
    if (x > 18'sd32767) begin
      r = 16'sh7FFF;
    end else if (x < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = x[15:0];
    end
    return r;
  endfunction

endpackage

[src/palette_error_diffusion_dither.sv]
// Top level of the palette error-diffusion ditherer with its search sequencer.
`timescale 1ns / 1ps
// Usage:
// The slave stream carries two kinds of transaction, chosen by s_tuser: a palette
// write (s_tuser = 0) loads one RGB entry of 16 bits per channel and produces no
// result; a pixel (s_tuser = 1) produces exactly one result on the master stream,
// the chosen palette index in m_tdata, with m_tlast marking the last pixel of a frame.
// Pixels arrive in raster order. A searched pixel is compared with N entries, where
// N is the number of entries searched (palette_size, with zero taken as one and larger
// values capped at PALETTE_DEPTH): the pipelined distance unit scores one palette entry per cycle,
// followed by pipeline drain and the row-store read-modify-write. Direct and
// transparent pixels skip the search. The block handles one pixel at a time and
// s_tready is low while a pixel is being worked on.
// After reset, and after the last pixel of every frame, the error row store is swept
// to zero, during which s_tready stays low; APB writes are still taken. A finished
// result sits in the output register; a new transaction can be accepted while it
// waits, but the next result is held back until the receiver takes the previous one,
// so a stalled receiver stalls the block without losing data.
// The APB port is always ready; registers should only be changed while idle.
module palette_error_diffusion_dither
  import pedd_pkg::*;
#(
  parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
  parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // entry_index[7:0], entry_red[23:8], entry_green[39:24], entry_blue[55:40],
  // pixel_red[63:56], pixel_green[71:64], pixel_blue[79:72], pixel_transparent[80],
  // direct_valid[81], direct_index[89:82], zero fill above.
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // operation[0]
  input  logic [0:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // color_index[7:0]
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_AW-1:0]     paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int PW = $clog2(PALETTE_DEPTH);
  localparam int CW = (XW + 1 > 11) ? XW + 1 : 11;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SUM, S_SEARCH, S_ERR, S_WRX, S_WRL, S_EMIT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [8:0]  palette_size;
  logic        dither_enable;
  logic [10:0] image_width;
  logic [15:0] image_height;

  // Frame position and carried error.
  logic [XW-1:0]      column_count;
  logic [15:0]        row_count;
  logic signed [15:0] rc   [3];
  logic signed [15:0] diag [3];

  // Latched pixel.
  logic [7:0]        px [3];
  logic              pix_direct;
  logic              pix_transp;
  logic [7:0]        pix_dindex;
  logic [XW-1:0]     x_reg;
  logic              last_col;
  logic              last_row;
  logic              spread;
  logic [7:0]        idx_reg;
  logic signed [11:0] v    [3];
  logic signed [20:0] k257 [3];
  logic signed [12:0] err  [3];

  // Search pipeline.
  logic [8:0]    srch_cnt;
  logic          s1_v, s2_v, s3_v;
  logic [PW-1:0] s1_i, s2_i, s3_i;
  logic [41:0]   sq [3];
  logic [7:0]    s2_hi [3];
  logic [7:0]    s3_hi [3];
  logic [43:0]   s3_sum;
  logic [43:0]   best_d;
  logic [PW-1:0] best_i;
  logic [7:0]    best_hi [3];

  logic [XW-1:0] clr_cnt;

  // Memories.
  logic [47:0] pal_mem [PALETTE_DEPTH];
  logic [47:0] pal_q;
  logic [47:0] row_mem [MAX_WIDTH];
  logic [47:0] row_q;
  logic          row_we;
  logic [XW-1:0] row_waddr;
  logic [47:0]   row_wdata;
  logic [XW-1:0] row_raddr;

  // Stream fields.
  logic        in_accept;
  logic        op_pixel;
  logic [7:0]  entry_index;
  logic [47:0] entry_rgb;
  logic [7:0]  in_px [3];
  logic        in_transp;
  logic        in_dvalid;
  logic [7:0]  in_dindex;

  assign in_accept   = s_tvalid && s_tready;
  assign op_pixel    = s_tuser[0];
  assign entry_index = s_tdata[7:0];
  assign entry_rgb   = s_tdata[55:8];
  assign in_px[0]    = s_tdata[63:56];
  assign in_px[1]    = s_tdata[71:64];
  assign in_px[2]    = s_tdata[79:72];
  assign in_transp   = s_tdata[80];
  assign in_dvalid   = s_tdata[81];
  assign in_dindex   = s_tdata[89:82];

  assign s_tready = (state == S_IDLE);
  assign pready   = 1'b1;

  // Effective geometry: zero counts as one, oversized values saturate, and a
  // column count past the last column is treated as the last column.
  logic [CW-1:0] w_cfg, w_eff, col_ext, x_c;
  logic [15:0]   h_eff;
  logic [XW-1:0] x_now;
  logic          last_col_now, last_row_now;
  logic [8:0]    n_eff;

  always_comb begin
    w_cfg = CW'(image_width);
    if (w_cfg == '0) begin
      w_eff = CW'(1);
    end else if (w_cfg > CW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = w_cfg;
    end
    col_ext      = CW'(column_count);
    x_c          = (col_ext >= w_eff) ? (w_eff - CW'(1)) : col_ext;
    x_now        = x_c[XW-1:0];
    last_col_now = (x_c == (w_eff - CW'(1)));
    h_eff        = (image_height == 16'd0) ? 16'd1 : image_height;
    last_row_now = (({1'b0, row_count} + 17'd1) >= {1'b0, h_eff});
    if (palette_size == 9'd0) begin
      n_eff = 9'd1;
    end else if (palette_size > 9'(PALETTE_DEPTH)) begin
      n_eff = 9'(PALETTE_DEPTH);
    end else begin
      n_eff = palette_size;
    end
  end

  // APB register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      palette_size  <= PALETTE_SIZE_RST;
      dither_enable <= DITHER_ENABLE_RST;
      image_width   <= IMAGE_WIDTH_RST;
      image_height  <= IMAGE_HEIGHT_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_index_t'(paddr[3:2]))
        REG_PALETTE_SIZE:  palette_size  <= pwdata[8:0];
        REG_DITHER_ENABLE: dither_enable <= pwdata[0];
        REG_IMAGE_WIDTH:   image_width   <= pwdata[10:0];
        REG_IMAGE_HEIGHT:  image_height  <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_index_t'(paddr[3:2]))
      REG_PALETTE_SIZE:  prdata = {23'd0, palette_size};
      REG_DITHER_ENABLE: prdata = {31'd0, dither_enable};
      REG_IMAGE_WIDTH:   prdata = {21'd0, image_width};
      REG_IMAGE_HEIGHT:  prdata = {16'd0, image_height};
      default:           prdata = '0;
    endcase
  end

  // Palette memory: written on a palette transaction, read by the search.
  logic       pal_we;
  logic       issue;

  assign pal_we = in_accept && !op_pixel && ({1'b0, entry_index} < 9'(PALETTE_DEPTH));
  assign issue  = (state == S_SEARCH) && (srch_cnt < n_eff);

  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_mem[entry_index[PW-1:0]] <= entry_rgb;
    end
    pal_q <= pal_mem[srch_cnt[PW-1:0]];
  end

  // Error row memory.
  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
    row_q <= row_mem[row_raddr];
  end

  // Update arithmetic for the row store and the carried errors.
  logic              sd;
  logic signed [15:0] cur  [3];
  logic signed [15:0] upd  [3];
  logic signed [15:0] rc_n [3];
  logic signed [15:0] dg_n [3];
  logic signed [15:0] rowch [3];
  logic signed [15:0] q    [3];
  logic signed [11:0] v_n  [3];
  logic signed [16:0] qa;
  logic signed [17:0] qsum;

  assign sd = spread && !last_row;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rowch[c] = $signed(row_q[16*c +: 16]);
      qsum     = 18'($signed({1'b0, px[c], 4'b0000})) + 18'(rc[c]) + 18'(rowch[c]);
      q[c]     = sat16(qsum);
      // Truncate toward zero when dividing by sixteen.
      qa       = 17'(q[c]) + (q[c][15] ? 17'sd15 : 17'sd0);
      v_n[c]   = 12'(qa >>> 4);
      cur[c]   = sd ? sat16(18'(diag[c]) + 18'(err[c]) * 18'sd5) : diag[c];
      upd[c]   = sat16(18'(rowch[c]) + 18'(err[c]) * 18'sd3);
      rc_n[c]  = (spread && !last_col) ? sat16(18'(err[c]) * 18'sd7) : 16'sd0;
      dg_n[c]  = (sd && !last_col) ? 16'(err[c]) : 16'sd0;
    end
  end

  always_comb begin
    row_we    = 1'b0;
    row_waddr = x_reg;
    row_wdata = {cur[2], cur[1], cur[0]};
    row_raddr = x_reg;
    case (state)
      S_CLEAR: begin
        row_we    = 1'b1;
        row_waddr = clr_cnt;
        row_wdata = '0;
      end
      S_IDLE: begin
        row_raddr = x_now;
      end
      S_WRX: begin
        row_we    = 1'b1;
        row_raddr = x_reg - XW'(1);
      end
      S_WRL: begin
        row_we    = sd && (x_reg != '0);
        row_waddr = x_reg - XW'(1);
        row_wdata = {upd[2], upd[1], upd[0]};
      end
      default: begin
      end
    endcase
  end

  // Distance unit: squared differences, then their sum, then the running minimum.
  logic signed [21:0] diff;
  logic signed [43:0] prod [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      diff    = $signed({6'd0, pal_q[16*c +: 16]}) - 22'(k257[c]);
      prod[c] = 44'(diff) * 44'(diff);
    end
  end

  always_ff @(posedge clk) begin
    s1_i <= srch_cnt[PW-1:0];
    s2_i <= s1_i;
    s3_i <= s2_i;
    for (int c = 0; c < 3; c++) begin
      sq[c]    <= prod[c][41:0];
      s2_hi[c] <= pal_q[16*c+8 +: 8];
      s3_hi[c] <= s2_hi[c];
    end
    s3_sum <= 44'(sq[0]) + 44'(sq[1]) + 44'(sq[2]);
    if (s3_v && ((s3_i == '0) || (s3_sum < best_d))) begin
      best_d  <= s3_sum;
      best_i  <= s3_i;
      best_hi <= s3_hi;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_cnt      <= '0;
      column_count <= '0;
      row_count    <= '0;
      m_tvalid     <= 1'b0;
      s1_v         <= 1'b0;
      s2_v         <= 1'b0;
      s3_v         <= 1'b0;
      srch_cnt     <= '0;
      for (int c = 0; c < 3; c++) begin
        rc[c]   <= '0;
        diag[c] <= '0;
      end
    end else begin
      s1_v <= issue;
      s2_v <= s1_v;
      s3_v <= s2_v;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + XW'(1);
          if (clr_cnt == XW'(MAX_WIDTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_accept && op_pixel) begin
            px         <= in_px;
            pix_direct <= in_dvalid;
            pix_transp <= in_transp;
            pix_dindex <= in_dindex;
            x_reg      <= x_now;
            last_col   <= last_col_now;
            last_row   <= last_row_now;
            state      <= S_SUM;
          end
        end
        S_SUM: begin
          for (int c = 0; c < 3; c++) begin
            v[c]    <= v_n[c];
            k257[c] <= (21'(v_n[c]) <<< 8) + 21'(v_n[c]);
            err[c]  <= '0;
            rc[c]   <= '0;
          end
          spread   <= 1'b0;
          srch_cnt <= '0;
          if (pix_direct) begin
            idx_reg <= pix_dindex;
            state   <= S_WRX;
          end else if (pix_transp) begin
            idx_reg <= TRANSPARENT_INDEX;
            state   <= S_WRX;
          end else begin
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (issue) begin
            srch_cnt <= srch_cnt + 9'd1;
          end else if (!s1_v && !s2_v && !s3_v) begin
            state <= S_ERR;
          end
        end
        S_ERR: begin
          for (int c = 0; c < 3; c++) begin
            err[c] <= 13'(v[c]) - $signed({5'd0, best_hi[c]});
          end
          idx_reg <= 8'(best_i);
          spread  <= dither_enable;
          state   <= S_WRX;
        end
        S_WRX: begin
          rc    <= rc_n;
          diag  <= dg_n;
          state <= S_WRL;
        end
        S_WRL: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= idx_reg;
            m_tlast  <= last_col && last_row;
            if (last_col) begin
              column_count <= '0;
              if (last_row) begin
                row_count <= '0;
                clr_cnt   <= '0;
                state     <= S_CLEAR;
              end else begin
                row_count <= row_count + 16'd1;
                state     <= S_IDLE;
              end
            end else begin
              column_count <= x_reg + XW'(1);
              state        <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

endmodule

[src/pedd_checker.sv]
// Port-level checker for the palette ditherer, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pedd_port_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [0:0] s_tuser,
  input logic       m_tvalid,
  input logic       m_tready
);

  // A result waiting for the receiver stays offered.
  `ASSERT_RST(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")

  // Reset leaves no result pending and starts the row-store sweep.
  `ASSERT_ALWAYS(a_reset_state, clk, rst |=> !m_tvalid && !s_tready, "reset did not clear the block")

  // A pixel transaction occupies the block for at least the following cycle.
  `ASSERT_RST(a_pixel_busy, clk, rst, s_tvalid && s_tready && s_tuser[0] |=> !s_tready, "pixel did not start work")

  // A palette write leaves the block ready for the next transaction.
  `ASSERT_RST(a_pal_ready, clk, rst, s_tvalid && s_tready && !s_tuser[0] |=> s_tready, "palette write stalled input")

endmodule

bind palette_error_diffusion_dither pedd_port_checker u_pedd_port_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);

[tb/pedd_checker.sv]
// Checker for the palette ditherer: tracks registers, predicts each pixel and compares results.
`timescale 1ns / 1ps
module pedd_checker
  import pedd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [0:0]            s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  m_tlast,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_AW-1:0]     paddr,
  input  logic [31:0]           pwdata,
  input  logic                  pready,
  output int                    fail_count,
  output int                    pending
);

  localparam int ROW_LEN = MAX_WIDTH_DEF;
  localparam int DEPTH   = PALETTE_DEPTH_DEF;

  typedef struct packed {
    logic [7:0] index;
    logic       frame_last;
  } pixel_result_t;

  logic [15:0] palette [DEPTH][3];
  int row_err [ROW_LEN][3];
  int right_carry [3];
  int diag_carry [3];
  int col, row;
  int pal_size, dither_on, img_width, img_height;
  pixel_result_t index_q [$];

  function automatic int clamp_acc(input int x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  function automatic void clear_errors();
    for (int i = 0; i < ROW_LEN; i++) begin
      for (int c = 0; c < 3; c++) row_err[i][c] = 0;
    end
    for (int c = 0; c < 3; c++) begin
      right_carry[c] = 0;
      diag_carry[c] = 0;
    end
  endfunction

  function automatic int closest_entry(input int v [3]);
    int n;
    int best;
    longint best_d, d, diff;
    n = pal_size;
    best = 0;
    best_d = 0;
    if (n < 1) n = 1;
    if (n > DEPTH) n = DEPTH;
    for (int m = 0; m < n; m++) begin
      d = 0;
      for (int c = 0; c < 3; c++) begin
        diff = longint'(palette[m][c]) - 257 * longint'(v[c]);
        d += diff * diff;
      end
      // Strict compare keeps the first entry on a tie.
      if (m == 0 || d < best_d) begin
        best_d = d;
        best = m;
      end
    end
    return best;
  endfunction

  function automatic pixel_result_t dither_pixel(input logic [IN_DATA_W-1:0] d);
    int w, h, x, idx, cur;
    bit last_col, last_row, down, spread;
    int v [3];
    int e [3];
    int px [3];
    pixel_result_t r;
    px[0] = d[63:56];
    px[1] = d[71:64];
    px[2] = d[79:72];
    w = img_width;
    if (w < 1) w = 1;
    if (w > ROW_LEN) w = ROW_LEN;
    h = img_height;
    if (h < 1) h = 1;
    x = col;
    if (x >= w) x = w - 1;
    last_col = (x + 1 >= w);
    last_row = (row + 1 >= h);
    down = !last_row;
    spread = 0;
    for (int c = 0; c < 3; c++) begin
      v[c] = clamp_acc(px[c] * 16 + right_carry[c] + row_err[x][c]) / 16;
      right_carry[c] = 0;
      e[c] = 0;
    end
    if (d[81]) begin
      idx = d[89:82];
    end else if (d[80]) begin
      idx = TRANSPARENT_INDEX;
    end else begin
      idx = closest_entry(v);
      for (int c = 0; c < 3; c++) e[c] = v[c] - int'(palette[idx][c] >> 8);
      spread = (dither_on != 0);
    end
    for (int c = 0; c < 3; c++) begin
      cur = diag_carry[c];
      if (spread && down) begin
        cur += 5 * e[c];
        if (x > 0) row_err[x-1][c] = clamp_acc(row_err[x-1][c] + 3 * e[c]);
      end
      row_err[x][c] = clamp_acc(cur);
      diag_carry[c] = (spread && down && !last_col) ? clamp_acc(e[c]) : 0;
      right_carry[c] = (spread && !last_col) ? clamp_acc(7 * e[c]) : 0;
    end
    r.index = idx[7:0];
    r.frame_last = 1'b0;
    if (last_col) begin
      col = 0;
      for (int c = 0; c < 3; c++) begin
        right_carry[c] = 0;
        diag_carry[c] = 0;
      end
      if (last_row) begin
        row = 0;
        clear_errors();
        r.frame_last = 1'b1;
      end else begin
        row = (row + 1) & 16'hFFFF;
      end
    end else begin
      col = x + 1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    pixel_result_t want;
    if (rst) begin
      clear_errors();
      col = 0;
      row = 0;
      pal_size = PALETTE_SIZE_RST;
      dither_on = DITHER_ENABLE_RST;
      img_width = IMAGE_WIDTH_RST;
      img_height = IMAGE_HEIGHT_RST;
      index_q.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_index_t'(paddr[3:2]))
          REG_PALETTE_SIZE:  pal_size = pwdata[8:0];
          REG_DITHER_ENABLE: dither_on = pwdata[0];
          REG_IMAGE_WIDTH:   img_width = pwdata[10:0];
          REG_IMAGE_HEIGHT:  img_height = pwdata[15:0];
          default: ;
        endcase
      end
      // Compare before pushing: a result can never belong to a pixel taken at this edge.
      if (m_tvalid && m_tready) begin
        if (index_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result index %0d last %0b", m_tdata, m_tlast);
          fail_count++;
        end else begin
          want = index_q.pop_front();
          if (m_tdata !== want.index || m_tlast !== want.frame_last) begin
            if (fail_count < 10) begin
              $display("mismatch: expected index %0d last %0b, got index %0d last %0b",
                       want.index, want.frame_last, m_tdata, m_tlast);
            end
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == OP_PALETTE_WRITE) begin
          palette[s_tdata[7:0]][0] = s_tdata[23:8];
          palette[s_tdata[7:0]][1] = s_tdata[39:24];
          palette[s_tdata[7:0]][2] = s_tdata[55:40];
        end else begin
          index_q.push_back(dither_pixel(s_tdata));
        end
      end
    end
    pending = index_q.size();
  end

endmodule

[tb/tb_palette_error_diffusion_dither.sv]
// Testbench top for the palette ditherer: stimulus, flow control and the verdict.
`timescale 1ns / 1ps
module tb_palette_error_diffusion_dither;
  import pedd_pkg::*;

  // Extra idle cycles once every expected result has come.
  localparam int DRAIN_CYCLES = 300;
  localparam int TARGET_ITEMS = 1150;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  // entry_index, entry_red, entry_green, entry_blue, pixel_red, pixel_green,
  // pixel_blue, pixel_transparent, direct_valid, direct_index, zero fill above.
  logic [IN_DATA_W-1:0]  s_tdata;
  // operation
  logic [0:0]            s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  // color_index
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;
  logic                  psel, penable, pwrite, pready;
  logic [CFG_AW-1:0]     paddr;
  logic [31:0]           pwdata, prdata;
  int                    fail_count;
  int                    pending;
  int                    items_sent;
  // Entries 0 .. filled-1 have been written; the searched size never exceeds this.
  int                    filled;

  palette_error_diffusion_dither dut (.*);

  pedd_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Most gaps are short, a few are long, and half of the time there is none at all.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_level();
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [15:0] pick_channel();
    if ($urandom_range(0, 5) == 0) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    return 16'($urandom_range(0, 65535));
  endfunction

  // One APB write: a setup phase, then an access phase.
  task automatic reg_write(input reg_index_t idx, input logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= CFG_AW'(idx) << 2;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Presents one transaction and holds it until accepted, then maybe idles.
  task automatic send_item(input logic [0:0] op, input logic [IN_DATA_W-1:0] data);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= data;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_entry(input logic [7:0] idx, input logic [15:0] r, input logic [15:0] g,
                            input logic [15:0] b);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[7:0] = idx;
    d[23:8] = r;
    d[39:24] = g;
    d[55:40] = b;
    send_item(OP_PALETTE_WRITE, d);
    if (int'(idx) == filled) filled++;
  endtask

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic clear, input logic direct, input logic [7:0] dix);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[63:56] = r;
    d[71:64] = g;
    d[79:72] = b;
    d[80] = clear;
    d[81] = direct;
    d[89:82] = dix;
    send_item(OP_PIXEL, d);
  endtask

  // Registers change only once the block has gone quiet. The extra edge lets the
  // checker count a pixel taken at the last edge before the pending count is read.
  task automatic quiesce();
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input int size, input int dither, input int width, input int height);
    quiesce();
    reg_write(REG_PALETTE_SIZE, size);
    reg_write(REG_DITHER_ENABLE, dither);
    reg_write(REG_IMAGE_WIDTH, width);
    reg_write(REG_IMAGE_HEIGHT, height);
  endtask

  // A run of random transactions. While the palette is incomplete, writes are
  // frequent and go to the next free entry so the written range stays contiguous.
  task automatic random_run(input int count);
    int kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 99);
      if (filled < PALETTE_DEPTH_DEF && kind < 60) begin
        load_entry(filled[7:0], pick_channel(), pick_channel(), pick_channel());
      end else if (kind < 12) begin
        load_entry(8'($urandom_range(0, 255)), pick_channel(), pick_channel(), pick_channel());
      end else if (kind < 18) begin
        send_pixel(pick_level(), pick_level(), pick_level(), 1'b1, 1'b0,
                   8'($urandom_range(0, 255)));
      end else if (kind < 24) begin
        send_pixel(pick_level(), pick_level(), pick_level(), 1'($urandom_range(0, 1)), 1'b1,
                   8'($urandom_range(0, 255)));
      end else begin
        send_pixel(pick_level(), pick_level(), pick_level(), 1'b0, 1'b0,
                   8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    int phase;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tuser <= OP_PALETTE_WRITE;
    s_tdata <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    items_sent = 0;
    filled = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed frame: 3 x 2 with a four-entry palette whose last entry ties with entry 1.
    configure(4, 1, 3, 2);
    load_entry(8'd0, 16'h0000, 16'h0000, 16'h0000);
    load_entry(8'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    load_entry(8'd2, 16'hFFFF, 16'h0000, 16'h0000);
    load_entry(8'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 8'h00);
    send_pixel(8'h80, 8'h40, 8'hC8, 1'b1, 1'b0, 8'h00);
    // Direct and transparent together: the direct index wins.
    send_pixel(8'h10, 8'h20, 8'h30, 1'b1, 1'b1, 8'hAA);
    send_pixel(8'hFF, 8'h00, 8'hFF, 1'b0, 1'b1, 8'h55);
    send_pixel(8'hC0, 8'h7F, 8'h01, 1'b0, 1'b0, 8'h00);
    // Dither off, then the zero settings that are taken as one.
    configure(4, 0, 2, 1);
    send_pixel(8'h7F, 8'h80, 8'h81, 1'b0, 1'b0, 8'h00);
    send_pixel(8'h01, 8'hFE, 8'h00, 1'b0, 1'b0, 8'h00);
    configure(0, 1, 0, 0);
    send_pixel(8'hFF, 8'hFF, 8'h00, 1'b0, 1'b0, 8'h00);
    send_pixel(8'h00, 8'hFF, 8'hFF, 1'b0, 1'b0, 8'h00);

    // Random phases with settings that sweep the extremes, then random settings.
    phase = 0;
    while (items_sent < TARGET_ITEMS) begin
      case (phase)
        0: begin
          // Fills the rest of the palette while pixels keep flowing.
          configure(4, 1, 5, 3);
          while (filled < PALETTE_DEPTH_DEF) random_run(1);
        end
        1: begin configure(256, 1, 8, 4); random_run(90); end
        2: begin configure(1, 1, 4, 2); random_run(40); end
        3: begin configure(256, 0, 6, 3); random_run(60); end
        4: begin configure($urandom_range(1, 256), 1, 1, 7); random_run(40); end
        5: begin configure(256, 1, 1024, 65535); random_run(30); end
        // Narrower image while the previous frame is still open.
        6: begin configure($urandom_range(1, 64), 1, 8, 3); random_run(50); end
        7: begin configure(511, 1, 2047, 2); random_run(20); end
        8: begin configure(16, 1, 7, 1); random_run(40); end
        default: begin
          configure($urandom_range(0, 3) == 0 ? $urandom_range(1, 256) : $urandom_range(1, 32),
                    $urandom_range(0, 3) != 0, $urandom_range(1, 16), $urandom_range(1, 6));
          random_run($urandom_range(40, 120));
        end
      endcase
      phase++;
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Receiver: bursts of readiness broken by random stalls.
  initial begin
    int gap;
    m_tready <= 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    #(64'd20_000_000 * 20);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

[palette_error_diffusion_dither.f]
+incdir+src
src/pedd_pkg.sv
src/palette_error_diffusion_dither.sv
src/pedd_checker.sv
tb/pedd_checker.sv
tb/tb_palette_error_diffusion_dither.sv
